// ===== hdl/ppd_pkg.sv =====
// Package for the pedal position hysteresis detector: item types, register
// codes, pedal state codes and the divide-by-50 reciprocal constants. No dependencies.
package ppd_pkg;

   localparam int RatioWidth    = 16;
   localparam int PositionWidth = 8;

   // Rounding divides (ratio + 25) by 50 through a reciprocal multiply.
   // The reciprocal 83887 / 2^22 is exact for every dividend below 2^22 / 46.
   localparam int                 QuotWidth   = 11;
   localparam int                 SumWidth    = RatioWidth + 1;
   localparam int                 RecipShift  = 22;
   localparam logic [16:0]        RecipMult   = 17'd83887;
   localparam logic [SumWidth-1:0] RoundBias  = SumWidth'(25);
   localparam logic [15:0]        RatioDiv    = 16'd50;

   typedef enum logic [1:0] {
      CSR_LIFT_LOW   = 2'd0,
      CSR_LIFT_HIGH  = 2'd1,
      CSR_FLOOR_LOW  = 2'd2,
      CSR_FLOOR_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PEDAL_LIFTED  = 2'd0,
      PEDAL_PARTIAL = 2'd1,
      PEDAL_FLOORED = 2'd2
   } pedal_code_type;

   typedef struct packed {
      logic [RatioWidth-1:0]    pedal_ratio;
      logic [PositionWidth-1:0] limiter_position;
      logic [PositionWidth-1:0] regulator_position;
      logic                     bench_dynamic;
      logic                     bench_static;
   } req_type;

   typedef struct packed {
      logic [PositionWidth-1:0] relative_position;
      logic                     foot_lifted;
      logic                     foot_floored;
      logic [1:0]               pedal_state;
      logic                     foot_lifted_final;
   } rsp_type;

   typedef struct packed {
      logic [RatioWidth-1:0] lift_low;
      logic [RatioWidth-1:0] lift_high;
      logic [RatioWidth-1:0] floor_low;
      logic [RatioWidth-1:0] floor_high;
   } cfg_type;

   // Payload between the position stage and the detector stage.
   typedef struct packed {
      logic [RatioWidth-1:0]    pedal_ratio;
      logic [PositionWidth-1:0] position;
      logic                     freeze;
   } pos_type;

endpackage

// ===== hdl/ppd_position.sv =====
// Position stage: rounds the ratio by 50, floors at the regulator and caps at
// the limiter, and registers the result. Depends on ppd_pkg.
module ppd_position
   import ppd_pkg::*;
(
   input  logic    clock,
   input  logic    load,
   input  req_type item,
   output pos_type pos_out
);

   logic [SumWidth-1:0]             round_sum;
   logic [SumWidth+17-1:0]          product;
   logic [QuotWidth-1:0]            quotient;
   logic [QuotWidth-1:0]            floored;
   logic [QuotWidth-1:0]            capped;
   pos_type                         pos_in;
   pos_type                         pos_ff;

   always_comb begin
      round_sum = SumWidth'(item.pedal_ratio) + RoundBias;
      product   = (SumWidth+17)'(round_sum) * (SumWidth+17)'(RecipMult);
      quotient  = product[RecipShift +: QuotWidth];
      // raise to the regulator first, then cap so the limiter wins
      floored = (quotient < QuotWidth'(item.regulator_position)) ?
                QuotWidth'(item.regulator_position) : quotient;
      capped  = (floored > QuotWidth'(item.limiter_position)) ?
                QuotWidth'(item.limiter_position) : floored;
      pos_in.pedal_ratio = item.pedal_ratio;
      pos_in.position    = capped[PositionWidth-1:0];
      pos_in.freeze      = item.bench_dynamic | item.bench_static;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= pos_in;
      end
   end

   assign pos_out = pos_ff;

endmodule

// ===== hdl/ppd_detect.sv =====
// Detector stage: three hysteresis comparators and the pedal state code; its
// registers are both the held state and the result payload. Depends on ppd_pkg.
module ppd_detect
   import ppd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  pos_type pos_in,
   input  cfg_type cfg,
   output rsp_type result
);

   rsp_type     result_in;
   rsp_type     result_ff;
   logic [15:0] pos_next_x50;
   logic [15:0] pos_x50;
   logic        lifted;
   logic        floored;
   logic        final_lifted;

   always_comb begin
      // pos < floor(lo/50) is 50*(pos+1) <= lo; pos > floor(hi/50) is 50*pos > hi
      pos_x50      = 16'(pos_in.position) * RatioDiv;
      pos_next_x50 = pos_x50 + RatioDiv;

      if (pos_in.pedal_ratio < cfg.lift_low) begin
         lifted = 1'b1;
      end else if (pos_in.pedal_ratio > cfg.lift_high) begin
         lifted = 1'b0;
      end else begin
         lifted = result_ff.foot_lifted;
      end

      if (pos_in.pedal_ratio > cfg.floor_high) begin
         floored = 1'b1;
      end else if (pos_in.pedal_ratio < cfg.floor_low) begin
         floored = 1'b0;
      end else begin
         floored = result_ff.foot_floored;
      end

      if (pos_next_x50 <= cfg.lift_low) begin
         final_lifted = 1'b1;
      end else if (pos_x50 > cfg.lift_high) begin
         final_lifted = 1'b0;
      end else begin
         final_lifted = result_ff.foot_lifted_final;
      end

      result_in.relative_position = pos_in.position;
      result_in.foot_lifted       = lifted;
      result_in.foot_floored      = floored;
      result_in.foot_lifted_final = final_lifted;
      if (lifted) begin
         result_in.pedal_state = PEDAL_LIFTED;
      end else if (floored) begin
         result_in.pedal_state = PEDAL_FLOORED;
      end else begin
         result_in.pedal_state = PEDAL_PARTIAL;
      end
   end

   // hold everything while a test bed flag is set
   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else if (load && !pos_in.freeze) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== hdl/pedal_position_hysteresis_detector.sv =====
// Top level of the pedal position hysteresis detector: handshakes, input
// register, threshold registers. Depends on ppd_pkg, ppd_position, ppd_detect.
//
//   port group   direction  handshake              payload
//   req_         in         req_valid / req_ready  req_data  (req_type)
//   rsp_         out        rsp_valid / rsp_ready  rsp_data  (rsp_type)
//   csr_         in         csr_valid / csr_ready  csr_index, csr_data
//
// Each item passes three registers: input, position, result, and appears on
// rsp_ from the result register; one item can enter every cycle unless a
// low rsp_ready stalls the pipeline. The hysteresis flags feed back within the
// result stage, so only a held-low rsp_ready stalls the input.
// Reset clears the stage valids, the thresholds and the held result to zero.
// A stalled rsp_ready fills the three stages, then drops req_ready.
module pedal_position_hysteresis_detector
   import ppd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [RatioWidth-1:0] csr_data
);

   req_type req_ff;
   logic    in_valid_ff;
   logic    pos_valid_ff;
   logic    out_valid_ff;
   logic    out_adv;
   logic    pos_adv;
   logic    in_adv;
   logic    req_take;
   cfg_type cfg_ff;
   cfg_type cfg_in;
   pos_type pos_item;

   // advance a stage when the next one is empty or draining
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign pos_adv   = !pos_valid_ff || out_adv;
   assign in_adv    = !in_valid_ff  || pos_adv;
   assign req_ready = in_adv;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_valid_ff <= req_valid;
         end
         if (pos_adv) begin
            pos_valid_ff <= in_valid_ff;
         end
         if (out_adv) begin
            out_valid_ff <= pos_valid_ff;
         end
      end
   end

   // hold the input item until the position stage takes it
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   // threshold registers; every write is taken at once
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LIFT_LOW:   cfg_in.lift_low   = csr_data;
            CSR_LIFT_HIGH:  cfg_in.lift_high  = csr_data;
            CSR_FLOOR_LOW:  cfg_in.floor_low  = csr_data;
            CSR_FLOOR_HIGH: cfg_in.floor_high = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppd_position u_position (
      .clock   (clock),
      .load    (pos_adv && in_valid_ff),
      .item    (req_ff),
      .pos_out (pos_item)
   );

   // the detector registers double as the held state across frozen items
   ppd_detect u_detect (
      .clock  (clock),
      .reset  (reset),
      .load   (out_adv && pos_valid_ff),
      .pos_in (pos_item),
      .cfg    (cfg_ff),
      .result (rsp_data)
   );

   assign rsp_valid = out_valid_ff;

endmodule
